// ----- rtl/bplf_pkg.sv -----
// Shared constants for the button-press light fade block.
`default_nettype none
package bplf_pkg;

  localparam int NUM_LIGHTS_DEF = 32;
  localparam int IDX_W          = 5;
  localparam int TIMER_W        = 17;
  localparam int MS_W           = 16;
  localparam int MASK_W         = 32;
  localparam int COLOR_W        = 24;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int S_TDATA_W      = 48;
  localparam int M_TDATA_W      = 32;
  localparam int MAG_W          = CH_W + MS_W;
  localparam int NUM_W          = MAG_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_COLOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_COLOR    = 3'd5;

  localparam logic               ENABLE_RST        = 1'b1;
  localparam logic [MS_W-1:0]    HOLD_MS_RST       = 16'd1;
  localparam logic [MS_W-1:0]    FADE_MS_RST       = 16'd0;
  localparam logic [MASK_W-1:0]  BUTTON_MASK_RST   = 32'd0;
  localparam logic [COLOR_W-1:0] PRESSED_COLOR_RST = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] IDLE_COLOR_RST    = 24'h000000;

endpackage
`default_nettype wire

// ----- rtl/button_press_led_fade.sv -----
// Button-press light fade: per-light countdowns in a RAM, colour blend per light.
//
//  channel   | signals                         | payload
//  ----------+---------------------------------+-------------------------------------
//  frame in  | s_tvalid s_tready s_tdata       | pressed_mask, elapsed_ms
//  color out | m_tvalid m_tready m_tdata/tuser | light_index, red, green, blue,
//            |   m_tlast                       |   new_press (tuser), last (tlast)
//  config    | cfg_wr_en cfg_index cfg_data    | register write, no read-back
//
// A blended light passes RAM read, read-modify-write, multiply, 8 restoring-divide
// steps and output load; a pressed or idle light skips the divider. A new frame is
// taken only in the idle state, after the last light of the frame is output.
// Reset (rst, synchronous) clears the countdown valid bits, so every countdown
// reads as zero until written; no clearing pass is needed. A stalled output
// holds the sequencer in its output state.
`default_nettype none
module button_press_led_fade #(
  parameter int NUM_LIGHTS = bplf_pkg::NUM_LIGHTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [31:0] pressed_mask, [47:32] elapsed_ms
  input  wire logic [bplf_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [4:0] light_index, [12:5] red, [20:13] green, [28:21] blue, [31:29] zero
  output logic [bplf_pkg::M_TDATA_W-1:0]        m_tdata,
  // [0] new_press
  output logic                                  m_tuser,
  output logic                                  m_tlast,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bplf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bplf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW     = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
  localparam int IDX_W  = bplf_pkg::IDX_W;
  localparam int TW     = bplf_pkg::TIMER_W;
  localparam int MW     = bplf_pkg::MS_W;
  localparam int CW     = bplf_pkg::CH_W;
  localparam int NCH    = bplf_pkg::NUM_CH;
  localparam int MAGW   = bplf_pkg::MAG_W;
  localparam int NUMW   = bplf_pkg::NUM_W;
  localparam int DSHW   = MW + CW - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LIGHTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_UPD, S_MUL, S_DIV, S_OUT
  } state_t;

  // configuration registers
  logic                                enable;
  logic [MW-1:0]                       hold_ms;
  logic [MW-1:0]                       fade_ms;
  logic [bplf_pkg::MASK_W-1:0]         button_mask;
  logic [bplf_pkg::COLOR_W-1:0]        pressed_color;
  logic [bplf_pkg::COLOR_W-1:0]        idle_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= bplf_pkg::ENABLE_RST;
      hold_ms       <= bplf_pkg::HOLD_MS_RST;
      fade_ms       <= bplf_pkg::FADE_MS_RST;
      button_mask   <= bplf_pkg::BUTTON_MASK_RST;
      pressed_color <= bplf_pkg::PRESSED_COLOR_RST;
      idle_color    <= bplf_pkg::IDLE_COLOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bplf_pkg::REG_ENABLE:        enable        <= cfg_data[0];
        bplf_pkg::REG_HOLD_MS:       hold_ms       <= cfg_data[MW-1:0];
        bplf_pkg::REG_FADE_MS:       fade_ms       <= cfg_data[MW-1:0];
        bplf_pkg::REG_BUTTON_MASK:   button_mask   <= cfg_data[bplf_pkg::MASK_W-1:0];
        bplf_pkg::REG_PRESSED_COLOR: pressed_color <= cfg_data[bplf_pkg::COLOR_W-1:0];
        bplf_pkg::REG_IDLE_COLOR:    idle_color    <= cfg_data[bplf_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // countdown RAM, registered read
  logic [TW-1:0] timer_mem [NUM_LIGHTS];
  logic [TW-1:0] rd_data;
  logic          wr_en;
  logic [TW-1:0] timer_next;
  logic [IDX_W-1:0] light;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      timer_mem[light[AW-1:0]] <= timer_next;
    end
    rd_data <= timer_mem[light[AW-1:0]];
  end

  state_t                   state;
  logic [NUM_LIGHTS-1:0]    vld;
  logic [bplf_pkg::MASK_W-1:0] pressed;
  logic [MW-1:0]            elapsed;
  logic [TW-1:0]            cur_t;
  logic                     fresh;
  logic [NCH-1:0][CW-1:0]   base;
  logic [NCH-1:0]           down;
  logic [NCH-1:0][NUMW-1:0] rem;
  logic [NCH-1:0][CW-1:0]   quo;
  logic [DSHW-1:0]          dsh;
  logic [2:0]               step;

  // read-modify-write of the countdown
  logic [TW-1:0] t_old;
  logic [MW-1:0] hold_eff;
  logic [TW-1:0] reload;
  logic          fresh_next;

  always_comb begin
    t_old      = vld[light[AW-1:0]] ? rd_data : '0;
    hold_eff   = (hold_ms == '0) ? MW'(1) : hold_ms;
    reload     = {1'b0, hold_eff} + {1'b0, fade_ms};
    timer_next = t_old;
    fresh_next = 1'b0;
    if (enable && button_mask[light]) begin
      if (pressed[light]) begin
        fresh_next = (t_old == '0);
        timer_next = reload;
      end else if (t_old != '0) begin
        timer_next = (t_old > {1'b0, elapsed}) ? t_old - {1'b0, elapsed} : '0;
      end
    end
    wr_en = (state == S_UPD);
  end

  // blend numerators: k * |end - start|, rounded up for falling channels
  logic [MW-1:0]            k;
  logic                     blend;
  logic [NCH-1:0][CW-1:0]   ch_s;
  logic [NCH-1:0][CW-1:0]   ch_e;
  logic [NCH-1:0][CW-1:0]   diff;
  logic [NCH-1:0][MAGW-1:0] mag;
  logic [NCH-1:0][NUMW-1:0] num;

  always_comb begin
    blend = (cur_t != '0) && (cur_t <= {1'b0, fade_ms});
    k     = fade_ms - cur_t[MW-1:0];
    for (int c = 0; c < NCH; c++) begin
      ch_s[c] = pressed_color[CW*c +: CW];
      ch_e[c] = idle_color[CW*c +: CW];
      diff[c] = (ch_e[c] >= ch_s[c]) ? ch_e[c] - ch_s[c] : ch_s[c] - ch_e[c];
      mag[c]  = {{MW{1'b0}}, diff[c]} * {{CW{1'b0}}, k};
      num[c]  = (ch_e[c] >= ch_s[c]) ? {1'b0, mag[c]}
              : {1'b0, mag[c]} + {{(NUMW-MW){1'b0}}, fade_ms} - NUMW'(1);
    end
  end

  // one restoring-divide step per channel; quotient is known to fit 8 bits
  logic [NCH-1:0]           ge;
  logic [NCH-1:0][CW-1:0]   col;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ge[c]  = rem[c] >= {{(NUMW-DSHW){1'b0}}, dsh};
      col[c] = down[c] ? base[c] - quo[c] : base[c] + quo[c];
    end
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vld      <= '0;
      light    <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // the output state decides valid on its own
      if (m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pressed <= s_tdata[bplf_pkg::MASK_W-1:0];
            elapsed <= s_tdata[bplf_pkg::MASK_W +: MW];
            light   <= '0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          vld[light[AW-1:0]] <= 1'b1;
          cur_t <= timer_next;
          fresh <= fresh_next;
          state <= S_MUL;
        end
        S_MUL: begin
          for (int c = 0; c < NCH; c++) begin
            quo[c] <= '0;
            rem[c] <= num[c];
            if (blend) begin
              base[c] <= ch_s[c];
              down[c] <= (ch_e[c] < ch_s[c]);
            end else begin
              base[c] <= (cur_t == '0) ? ch_e[c] : ch_s[c];
              down[c] <= 1'b0;
            end
          end
          dsh   <= {fade_ms, {(CW-1){1'b0}}};
          step  <= '0;
          state <= blend ? S_DIV : S_OUT;
        end
        S_DIV: begin
          for (int c = 0; c < NCH; c++) begin
            if (ge[c]) begin
              rem[c] <= rem[c] - {{(NUMW-DSHW){1'b0}}, dsh};
            end
            quo[c] <= {quo[c][CW-2:0], ge[c]};
          end
          dsh  <= dsh >> 1;
          step <= step + 3'd1;
          if (step == 3'(CW - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, col[0], col[1], col[2], light};
            m_tuser  <= fresh;
            m_tlast  <= (light == LAST_IDX);
            if (light == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              light <= light + IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
